FILE: hdl/assert_macros.svh
// Assertion helpers used by unsigned_checked_alu_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is held.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// A condition that must never be seen while out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `ASSERT_AT(lbl, clk, rstn, !(expr), msg)

`endif

FILE: hdl/uca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uca_pkg
// Operation, status and comparison codes of the checked unsigned ALU.
// ----------------------------------------------------------------------------
package uca_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    // Register stages in the multiplier, from operands to wrapped value and flag.
    localparam int MUL_LAT = 4;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_INC = 3'd4,
        OP_DEC = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_WRAP  = 2'd1,
        ST_DIV0  = 2'd2,
        ST_BADOP = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMP_EQ = 2'd0,
        CMP_LT = 2'd1,
        CMP_GT = 2'd2
    } cmp_t;

endpackage
`default_nettype wire

FILE: hdl/unsigned_checked_alu_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_checked_alu_unit
// Pipelined unsigned ALU with wrap, divide-by-zero and bad-operation status.
// ----------------------------------------------------------------------------
// Usage. An item (op, operand_a, operand_b) is taken at every rising edge at
// which start is high; busy is always low, so an item may be issued in every
// cycle and the block sustains one item per clock.
// Each item yields one result on value_out, status, compare_code and is_zero,
// marked by done for exactly one cycle. The delay from item to result is
// the same for every operation, so results leave in the order their items
// came in. That delay is set by the divider, which resolves one quotient
// bit per register stage; the four-stage multiplier and the combinational
// add, subtract, increment and decrement results are delayed to meet it.
// The receiver cannot hold results off, and none is needed: with a fixed
// latency and one result per item, nothing ever has to wait inside the block.
// Reset clears the valid bits of every stage, so items in flight are dropped
// and done stays low until fresh items have passed through.
// ----------------------------------------------------------------------------
module unsigned_checked_alu_unit
    import uca_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [2:0]            op,
    input  wire logic [DATA_WIDTH-1:0] operand_a,
    input  wire logic [DATA_WIDTH-1:0] operand_b,
    output logic                       done,
    output logic      [DATA_WIDTH-1:0] value_out,
    output logic      [1:0]            status,
    output logic      [1:0]            compare_code,
    output logic                       is_zero
);

`include "assert_macros.svh"

    localparam int W   = DATA_WIDTH;
    localparam int LAT = DATA_WIDTH;
    localparam int MD  = LAT - MUL_LAT;

    // Everything about an item except the multiplier and divider results.
    typedef struct packed {
        op_t          op;
        logic         b_zero;
        logic [W-1:0] value;
        status_t      status;
        cmp_t         cmp;
        logic         a_zero;
    } side_t;

    side_t        side_next;
    side_t        side_reg  [LAT];
    logic         valid_reg [LAT];
    logic [W-1:0] md_lo_reg [MD];
    logic         md_ovf_reg[MD];

    logic [W-1:0] mul_lo, quo;
    logic         mul_ovf;
    logic [W:0]   sum, diff;
    logic         a_max;

    logic         done_reg;
    logic [W-1:0] value_reg, value_next;
    status_t      status_reg, status_next;
    cmp_t         cmp_reg;
    logic         zero_reg;

    assign busy = 1'b0;

    uca_mul #(.W(W)) u_mul
    (
        .clk (clk),
        .a   (operand_a),
        .b   (operand_b),
        .lo  (mul_lo),
        .ovf (mul_ovf)
    );

    uca_div #(.W(W)) u_div
    (
        .clk      (clk),
        .a        (operand_a),
        .b        (operand_b),
        .quotient (quo)
    );

    // The short operations are settled as the item enters.
    assign sum   = {1'b0, operand_a} + {1'b0, operand_b};
    assign diff  = {1'b0, operand_a} - {1'b0, operand_b};
    assign a_max = &operand_a;

    always_comb
    begin
        side_next.op     = op_t'(op);
        side_next.b_zero = (operand_b == '0);
        side_next.a_zero = (operand_a == '0);
        if (operand_a == operand_b)
            side_next.cmp = CMP_EQ;
        else if (operand_a < operand_b)
            side_next.cmp = CMP_LT;
        else
            side_next.cmp = CMP_GT;
        side_next.value  = operand_a;
        side_next.status = ST_OK;
        case (op_t'(op))
            OP_ADD:
            begin
                side_next.value  = sum[W-1:0];
                side_next.status = sum[W] ? ST_WRAP : ST_OK;
            end
            OP_SUB:
            begin
                side_next.value  = diff[W-1:0];
                side_next.status = diff[W] ? ST_WRAP : ST_OK;
            end
            OP_MUL: side_next.status = ST_OK;
            OP_DIV: side_next.status = side_next.b_zero ? ST_DIV0 : ST_OK;
            OP_INC:
            begin
                side_next.value  = operand_a + W'(1);
                side_next.status = a_max ? ST_WRAP : ST_OK;
            end
            OP_DEC:
            begin
                side_next.value  = operand_a - W'(1);
                side_next.status = side_next.a_zero ? ST_WRAP : ST_OK;
            end
            default: side_next.status = ST_BADOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start;
            for (int i = 1; i < LAT; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0]   <= side_next;
        md_lo_reg[0]  <= mul_lo;
        md_ovf_reg[0] <= mul_ovf;
        for (int i = 1; i < LAT; i++)
            side_reg[i] <= side_reg[i-1];
        for (int i = 1; i < MD; i++)
        begin
            md_lo_reg[i]  <= md_lo_reg[i-1];
            md_ovf_reg[i] <= md_ovf_reg[i-1];
        end
    end

    // Final pick between the short path, the multiplier and the divider.
    always_comb
    begin
        value_next  = side_reg[LAT-1].value;
        status_next = side_reg[LAT-1].status;
        case (side_reg[LAT-1].op)
            OP_MUL:
            begin
                value_next  = md_lo_reg[MD-1];
                status_next = md_ovf_reg[MD-1] ? ST_WRAP : ST_OK;
            end
            OP_DIV:
            begin
                if (!side_reg[LAT-1].b_zero)
                    value_next = quo;
            end
            default: value_next = side_reg[LAT-1].value;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        cmp_reg    <= side_reg[LAT-1].cmp;
        zero_reg   <= side_reg[LAT-1].a_zero;
    end

    assign done         = done_reg;
    assign value_out    = value_reg;
    assign status       = status_reg;
    assign compare_code = cmp_reg;
    assign is_zero      = zero_reg;

    // Every result must trace back to an edge at which start took its item.
    `ASSERT_AT(a_done_follows_start, clk, rst_n, done |-> $past(start, LAT + 1),
        "result without a matching item")
    // A zero divisor can never exceed the first operand.
    `ASSERT_NEVER(a_div0_cmp, clk, rst_n,
        done && status == ST_DIV0 && compare_code == CMP_LT,
        "divide by zero reported with operand_a below operand_b")
    // A zero first operand can never be the greater one.
    `ASSERT_NEVER(a_zero_cmp, clk, rst_n, done && is_zero && compare_code == CMP_GT,
        "zero operand_a reported greater")

endmodule
`default_nettype wire

FILE: hdl/uca_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uca_mul
// Four-stage pipelined multiplier giving the wrapped product and a wrap flag.
// ----------------------------------------------------------------------------
module uca_mul
    import uca_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic      [W-1:0] lo,
    output logic              ovf
);

    localparam int HALF = (W + 1) / 2;
    localparam int PW   = 4 * HALF;

    logic [HALF-1:0]   al, ah, bl, bh;
    logic [2*HALF-1:0] pll_reg, plh_reg, phl_reg, phh_reg;
    logic [2*HALF-1:0] pll2_reg, phh2_reg;
    logic [2*HALF:0]   mid_reg;
    logic [PW-1:0]     prod_reg;
    logic [W-1:0]      lo_reg;
    logic              ovf_reg;

    assign al = a[HALF-1:0];
    assign ah = HALF'(a >> HALF);
    assign bl = b[HALF-1:0];
    assign bh = HALF'(b >> HALF);

    // Stage 1: four half-width partial products.
    // Stage 2: cross terms summed. Stage 3: full product. Stage 4: wrap check.
    always_ff @(posedge clk)
    begin
        pll_reg  <= al * bl;
        plh_reg  <= al * bh;
        phl_reg  <= ah * bl;
        phh_reg  <= ah * bh;
        mid_reg  <= {1'b0, plh_reg} + {1'b0, phl_reg};
        pll2_reg <= pll_reg;
        phh2_reg <= phh_reg;
        prod_reg <= {phh2_reg, pll2_reg} + (PW'(mid_reg) << HALF);
        lo_reg   <= prod_reg[W-1:0];
        ovf_reg  <= |prod_reg[PW-1:W];
    end

    assign lo  = lo_reg;
    assign ovf = ovf_reg;

endmodule
`default_nettype wire

FILE: hdl/uca_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uca_div
// Restoring divider pipelined one quotient bit per stage, W stages deep.
// ----------------------------------------------------------------------------
module uca_div
    import uca_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic      [W-1:0] quotient
);

    logic [W-1:0] rem_reg [W];
    logic [W-1:0] aq_reg  [W];
    logic [W-1:0] b_reg   [W];

    // The dividend shifts out at the top while quotient bits shift in below.
    for (genvar k = 0; k < W; k++)
    begin : g_stage
        logic [W-1:0] r_in, aq_in, b_in;
        logic [W:0]   trial;
        logic         ge;

        if (k == 0)
        begin : g_first
            assign r_in  = '0;
            assign aq_in = a;
            assign b_in  = b;
        end
        else
        begin : g_next
            assign r_in  = rem_reg[k-1];
            assign aq_in = aq_reg[k-1];
            assign b_in  = b_reg[k-1];
        end

        assign trial = {r_in, aq_in[W-1]};
        assign ge    = (trial >= {1'b0, b_in});

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? W'(trial - {1'b0, b_in}) : trial[W-1:0];
            aq_reg[k]  <= {aq_in[W-2:0], ge};
            b_reg[k]   <= b_in;
        end
    end

    assign quotient = aq_reg[W-1];

endmodule
`default_nettype wire
